// ===== rtl/csvfs_pkg.sv =====
// Package for the CSV field splitter: item types, parser state type and
// the character constants. Used by csvfs_parse and csv_field_splitter.
package csvfs_pkg;

  localparam logic [15:0] UNIT_BOM   = 16'hFEFF;
  localparam logic [15:0] UNIT_COMMA = 16'h002C;
  localparam logic [15:0] UNIT_QUOTE = 16'h0022;

  // Quote tracking codes. The fourth code is never reached and reads as outside.
  localparam logic [1:0] QM_OUT  = 2'd0;
  localparam logic [1:0] QM_IN   = 2'd1;
  localparam logic [1:0] QM_PEND = 2'd2;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic        has_unit;
    logic [15:0] code_unit;
    logic        line_end;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] cell_unit;
    logic        row_end;
  } out_item_t;

  typedef struct packed {
    logic [1:0] quote_mode;
    logic       cell_nonempty;
    logic       at_line_start;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{quote_mode: QM_OUT, cell_nonempty: 1'b0,
                                           at_line_start: 1'b1};

endpackage

// ===== rtl/csvfs_parse.sv =====
// Combinational parse step of the CSV field splitter: one input item and the
// current state give the next state and up to two result items. Uses csvfs_pkg.
module csvfs_parse import csvfs_pkg::*; (
  input  parse_state_t state,
  input  in_item_t     item,
  output parse_state_t state_next,
  output logic [1:0]   res_count,
  output out_item_t    res0,
  output out_item_t    res1
);

  always_comb begin
    logic [1:0]  qm;
    logic        ne;
    logic        do_outside;
    logic        have_char;
    logic        have_end;
    logic [15:0] char_val;
    out_item_t   first_res;
    out_item_t   last_end;

    qm         = state.quote_mode;
    ne         = state.cell_nonempty;
    do_outside = 1'b0;
    have_char  = 1'b0;
    have_end   = 1'b0;
    char_val   = item.code_unit;
    state_next = state;

    if (item.has_unit) begin
      state_next.at_line_start = 1'b0;
      if (!(state.at_line_start && item.code_unit == UNIT_BOM)) begin
        case (qm)
          QM_IN: begin
            if (item.code_unit == UNIT_QUOTE) begin
              qm = QM_PEND;
            end else begin
              have_char = 1'b1;
            end
          end
          QM_PEND: begin
            if (item.code_unit == UNIT_QUOTE) begin
              have_char = 1'b1;
              char_val  = UNIT_QUOTE;
              qm        = QM_IN;
            end else begin
              qm         = QM_OUT;
              do_outside = 1'b1;
            end
          end
          default: begin
            qm         = QM_OUT;
            do_outside = 1'b1;
          end
        endcase

        if (do_outside) begin
          if (item.code_unit == UNIT_COMMA) begin
            have_end = 1'b1;
            ne       = 1'b0;
          end else if (item.code_unit == UNIT_QUOTE && !ne) begin
            qm = QM_IN;
          end else begin
            have_char = 1'b1;
          end
        end
        if (have_char) begin
          ne = 1'b1;
        end
      end
    end
    state_next.quote_mode    = qm;
    state_next.cell_nonempty = ne;

    first_res.kind      = have_end ? KIND_END : KIND_CHAR;
    first_res.cell_unit = have_end ? 16'h0000 : char_val;
    first_res.row_end   = 1'b0;

    last_end.kind      = KIND_END;
    last_end.cell_unit = 16'h0000;
    last_end.row_end   = 1'b1;

    res0 = first_res;
    res1 = last_end;
    if (have_char || have_end) begin
      res_count = item.line_end ? 2'd2 : 2'd1;
    end else begin
      res_count = item.line_end ? 2'd1 : 2'd0;
      res0      = last_end;
    end

    if (item.line_end) begin
      state_next = STATE_RESET;
    end
  end

endmodule

// ===== rtl/csv_field_splitter.sv =====
// Top level of the CSV field splitter: input register, parse step and a
// four-entry result queue. Depends on csvfs_pkg and csvfs_parse.
//
//   channel | signals                      | payload
//   input   | in_valid / in_ready          | in_data  (in_item_t: unit, line end)
//   output  | out_valid / out_ready        | out_data (out_item_t: char or field end)
//
// An item is held in the input register, parsed there, and its results are
// written into the result queue, from which they are visible. One item is
// taken per cycle while the output drains and the queue has room for two results;
// the result queue moves one result per cycle, so an item that ends a field and the line at once gives two results.
// Reset clears the parser state and the input register's valid flag and empties the queue.
// A stalled output holds the input register once the queue lacks room for two.
module csv_field_splitter import csvfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);

  parse_state_t state;
  parse_state_t state_next;
  logic         s1_valid;
  in_item_t     s1_item;

  logic [1:0]   res_count;
  out_item_t    res0;
  out_item_t    res1;

  out_item_t    queue [QDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  logic pop;
  logic space_ok;
  logic s1_adv;
  logic [PtrW:0] push_n;

  csvfs_parse u_parse (
    .state      (state),
    .item       (s1_item),
    .state_next (state_next),
    .res_count  (res_count),
    .res0       (res0),
    .res1       (res1)
  );

  assign out_valid = (count != '0);
  assign out_data  = queue[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Room for the worst case of two results, counting this cycle's pop.
  assign space_ok = (count <= (PtrW+1)'(QDepth - 2)) ||
                    (pop && count == (PtrW+1)'(QDepth - 1));
  assign s1_adv   = s1_valid && space_ok;
  assign in_ready = !s1_valid || space_ok;
  assign push_n   = s1_adv ? (PtrW+1)'(res_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= STATE_RESET;
      s1_valid <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
        s1_item  <= in_data;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        state <= state_next;
        if (res_count != 2'd0) begin
          queue[wr_ptr] <= res0;
        end
        if (res_count == 2'd2) begin
          queue[wr_ptr + PtrW'(1)] <= res1;
        end
        wr_ptr <= wr_ptr + PtrW'(push_n);
      end

      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + push_n - (PtrW+1)'(pop);
    end
  end

endmodule
